FILE: sv/uvn_pkg.sv
// Package with shared types and constants for the unit vector normalizer.
`default_nettype none

package uvn_pkg;

    localparam int AXES_DEF   = 6;
    localparam int COMP_W     = 32;
    localparam int SQ_W       = 64;
    localparam int SUM_W      = 66;
    localparam int LEN_W      = 33;
    localparam int AXIS_W     = 3;
    localparam int QUO_W      = 31;
    localparam int SQRT_STEPS = 33;
    localparam int DIV_STEPS  = 31;
    localparam int STEP_W     = 6;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ACCUM,
        ST_ROOT_LOAD,
        ST_ROOT,
        ST_DIV_LOAD,
        ST_DIV,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic take;
        logic accum;
        logic root_init;
        logic root_step;
        logic div_init;
        logic div_step;
        logic emit;
        logic clear;
    } cmd_t;

    typedef struct packed {
        logic last_item;
        logic last_axis;
        logic out_free;
    } sts_t;

endpackage

`default_nettype wire

FILE: sv/uvn_ctrl.sv
// Controller state machine that sequences accumulation, square root and division.
`default_nettype none

module uvn_ctrl (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         in_valid,
    output logic              in_stall,
    input  uvn_pkg::sts_t     sts,
    output uvn_pkg::cmd_t     cmd
);
    import uvn_pkg::*;

    state_t             state_reg;
    state_t             state_next;
    logic [STEP_W-1:0]  step_reg;
    logic [STEP_W-1:0]  step_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_ACCUM;
                end
            end
            ST_ACCUM:
            begin
                state_next = sts.last_item ? ST_ROOT_LOAD : ST_IDLE;
            end
            ST_ROOT_LOAD:
            begin
                step_next  = '0;
                state_next = ST_ROOT;
            end
            ST_ROOT:
            begin
                step_next = step_reg + 1'b1;
                if (step_reg == STEP_W'(SQRT_STEPS - 1))
                begin
                    state_next = ST_DIV_LOAD;
                end
            end
            ST_DIV_LOAD:
            begin
                step_next  = '0;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                step_next = step_reg + 1'b1;
                if (step_reg == STEP_W'(DIV_STEPS - 1))
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (sts.out_free)
                begin
                    state_next = sts.last_axis ? ST_IDLE : ST_DIV_LOAD;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_stall = 1'b1;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                cmd.take = in_valid;
            end
            ST_ACCUM:
            begin
                cmd.accum = 1'b1;
            end
            ST_ROOT_LOAD:
            begin
                cmd.root_init = 1'b1;
            end
            ST_ROOT:
            begin
                cmd.root_step = 1'b1;
            end
            ST_DIV_LOAD:
            begin
                cmd.div_init = 1'b1;
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
            end
            ST_EMIT:
            begin
                cmd.emit  = sts.out_free;
                cmd.clear = sts.out_free & sts.last_axis;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

FILE: sv/uvn_dp.sv
// Datapath with component store, square accumulator, root and divide units, output register.
`default_nettype none

module uvn_dp #(
    parameter int AXES = uvn_pkg::AXES_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic [uvn_pkg::COMP_W-1:0]    component,
    input  uvn_pkg::cmd_t                      cmd,
    output uvn_pkg::sts_t                      sts,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic [uvn_pkg::AXIS_W-1:0]         axis_index,
    output logic [uvn_pkg::COMP_W-1:0]         unit_component,
    output logic [uvn_pkg::LEN_W-1:0]          length,
    output logic                               zero_length,
    output logic                               final_res
);
    import uvn_pkg::*;

    localparam int AW       = (AXES > 1) ? $clog2(AXES) : 1;
    localparam int ROOT_T_W = LEN_W + 3;
    localparam int REM_W    = LEN_W + 1;
    localparam int ONE_Q30  = 32'h4000_0000;

    logic [COMP_W-1:0]   store_reg [AXES];
    logic [AW-1:0]       cnt_reg;
    logic [AW-1:0]       axis_reg;
    logic [SQ_W-1:0]     sq_reg;
    logic [SUM_W-1:0]    sum_reg;
    logic                zero_reg;
    logic [SUM_W-1:0]    rad_reg;
    logic [REM_W-1:0]    rem_reg;
    logic [LEN_W-1:0]    root_reg;
    logic [LEN_W-1:0]    drem_reg;
    logic [QUO_W-1:0]    dbits_reg;
    logic [QUO_W-1:0]    quo_reg;
    logic                neg_reg;
    logic                out_valid_reg;
    logic [AXIS_W-1:0]   axis_out_reg;
    logic [COMP_W-1:0]   unit_reg;
    logic [LEN_W-1:0]    len_reg;
    logic                zero_out_reg;
    logic                final_reg;

    logic [COMP_W-1:0]   in_mag;
    logic [COMP_W-1:0]   sel_comp;
    logic [COMP_W-1:0]   sel_mag;
    logic [ROOT_T_W-1:0] root_t;
    logic [ROOT_T_W-1:0] root_trial;
    logic                root_ge;
    logic [LEN_W:0]      div_t;
    logic                div_ge;
    logic [COMP_W-1:0]   quo_clamp;
    logic [COMP_W-1:0]   unit_val;

    assign in_mag     = component[COMP_W-1] ? (~component + 1'b1) : component;
    assign sel_comp   = store_reg[axis_reg];
    assign sel_mag    = sel_comp[COMP_W-1] ? (~sel_comp + 1'b1) : sel_comp;

    assign root_t     = {rem_reg, rad_reg[SUM_W-1 -: 2]};
    assign root_trial = {1'b0, root_reg, 2'b01};
    assign root_ge    = (root_t >= root_trial);

    assign div_t      = {drem_reg, dbits_reg[QUO_W-1]};
    assign div_ge     = (div_t >= {1'b0, root_reg});

    assign quo_clamp  = ({1'b0, quo_reg} > COMP_W'(ONE_Q30)) ? COMP_W'(ONE_Q30)
                                                              : {1'b0, quo_reg};
    assign unit_val   = zero_reg ? '0 : (neg_reg ? (~quo_clamp + 1'b1) : quo_clamp);

    always_ff @(posedge clk)
    begin
        if (cmd.take)
        begin
            store_reg[cnt_reg] <= component;
            sq_reg             <= in_mag * in_mag;
        end
        if (cmd.root_init)
        begin
            rad_reg  <= sum_reg;
            rem_reg  <= '0;
            root_reg <= '0;
            zero_reg <= (sum_reg == '0);
        end
        else if (cmd.root_step)
        begin
            rad_reg <= {rad_reg[SUM_W-3:0], 2'b00};
            if (root_ge)
            begin
                rem_reg  <= REM_W'(root_t - root_trial);
                root_reg <= {root_reg[LEN_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg  <= REM_W'(root_t);
                root_reg <= {root_reg[LEN_W-2:0], 1'b0};
            end
        end
        if (cmd.div_init)
        begin
            drem_reg  <= LEN_W'(sel_mag[COMP_W-1:1]);
            dbits_reg <= {sel_mag[0], {(QUO_W-1){1'b0}}};
            quo_reg   <= '0;
            neg_reg   <= sel_comp[COMP_W-1];
        end
        else if (cmd.div_step)
        begin
            dbits_reg <= {dbits_reg[QUO_W-2:0], 1'b0};
            if (div_ge)
            begin
                drem_reg <= LEN_W'(div_t - {1'b0, root_reg});
                quo_reg  <= {quo_reg[QUO_W-2:0], 1'b1};
            end
            else
            begin
                drem_reg <= LEN_W'(div_t);
                quo_reg  <= {quo_reg[QUO_W-2:0], 1'b0};
            end
        end
        if (cmd.emit)
        begin
            axis_out_reg <= AXIS_W'(axis_reg);
            unit_reg     <= unit_val;
            len_reg      <= root_reg;
            zero_out_reg <= zero_reg;
            final_reg    <= (axis_reg == AW'(AXES - 1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= '0;
            axis_reg      <= '0;
            sum_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.clear)
            begin
                sum_reg <= '0;
                cnt_reg <= '0;
            end
            else if (cmd.accum)
            begin
                sum_reg <= sum_reg + {2'b00, sq_reg};
                if (cnt_reg != AW'(AXES - 1))
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                end
            end
            if (cmd.root_init)
            begin
                axis_reg <= '0;
            end
            else if (cmd.emit)
            begin
                axis_reg <= axis_reg + 1'b1;
            end
            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign sts.last_item  = (cnt_reg == AW'(AXES - 1));
    assign sts.last_axis  = (axis_reg == AW'(AXES - 1));
    assign sts.out_free   = !out_valid_reg || !out_stall;

    assign out_valid      = out_valid_reg;
    assign axis_index     = axis_out_reg;
    assign unit_component = unit_reg;
    assign length         = len_reg;
    assign zero_length    = zero_out_reg;
    assign final_res      = final_reg;

endmodule

`default_nettype wire

FILE: sv/unit_vector_normalizer_top.sv
// Top level of the unit vector normalizer: controller plus datapath.
// Each component is accumulated before the next is taken; the block stalls input while it works.
// After the last component the block loads and runs the 33-step square root, then for
// each axis loads and runs the shared 31-step divider and emits the result, waiting
// at the emit while the output is stalled.
// Asynchronous active-low reset clears the sum, the counters and the output valid.
`default_nettype none

module unit_vector_normalizer_top #(
    parameter int AXES = uvn_pkg::AXES_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic [uvn_pkg::COMP_W-1:0]    component,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic [uvn_pkg::AXIS_W-1:0]         axis_index,
    output logic [uvn_pkg::COMP_W-1:0]         unit_component,
    output logic [uvn_pkg::LEN_W-1:0]          length,
    output logic                               zero_length,
    output logic                               final_res
);
    import uvn_pkg::*;

    cmd_t cmd;
    sts_t sts;

    uvn_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    uvn_dp #(
        .AXES (AXES)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .component      (component),
        .cmd            (cmd),
        .sts            (sts),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .axis_index     (axis_index),
        .unit_component (unit_component),
        .length         (length),
        .zero_length    (zero_length),
        .final_res      (final_res)
    );

endmodule

`default_nettype wire

FILE: sv/uvn_checker.sv
// Port-level checker for the unit vector normalizer and its bind statement.
`default_nettype none

module uvn_checker (
    input wire logic                          clk,
    input wire logic                          rst_n,
    input wire logic                          in_valid,
    input wire logic                          in_stall,
    input wire logic                          out_valid,
    input wire logic                          out_stall,
    input wire logic [uvn_pkg::AXIS_W-1:0]    axis_index,
    input wire logic [uvn_pkg::COMP_W-1:0]    unit_component,
    input wire logic [uvn_pkg::LEN_W-1:0]     length,
    input wire logic                          zero_length,
    input wire logic                          final_res
);
    import uvn_pkg::*;

    // A stalled result transaction keeps its payload.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(unit_component)
            && $stable(length) && $stable(axis_index) && $stable(final_res))
        else $error("stalled result changed");

    // The block works on one component at a time.
    a_in_one: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input taken on consecutive cycles");

    a_zero_out: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && zero_length |-> unit_component == '0 && length == '0)
        else $error("zero vector gave nonzero output");

    a_len_nz: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !zero_length |-> length != '0)
        else $error("nonzero vector gave zero length");

    a_unit_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> $signed(unit_component) <= 32'sh4000_0000
            && $signed(unit_component) >= -32'sh4000_0000)
        else $error("unit component out of range");

endmodule

bind unit_vector_normalizer_top uvn_checker u_uvn_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .axis_index     (axis_index),
    .unit_component (unit_component),
    .length         (length),
    .zero_length    (zero_length),
    .final_res      (final_res)
);

`default_nettype wire

FILE: dv/tb.sv
// Testbench for unit_vector_normalizer_top: random and directed vectors checked against a predictor.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import uvn_pkg::*;

    localparam int AXES = AXES_DEF;
    localparam logic [31:0] MOST_NEG = 32'h8000_0000;
    localparam logic [31:0] MOST_POS = 32'h7fff_ffff;
    localparam logic [63:0] ONE_Q30 = 64'h4000_0000;

    typedef struct packed {
        logic [AXIS_W-1:0] axis;
        logic [COMP_W-1:0] unit;
        logic [LEN_W-1:0]  len;
        logic              zero;
        logic              last;
    } unit_result_t;

    logic                clk = 1'b0;
    logic                rst_n;
    logic                in_valid;
    logic                in_stall;
    logic [COMP_W-1:0]   component;
    logic                out_valid;
    logic                out_stall;
    logic [AXIS_W-1:0]   axis_index;
    logic [COMP_W-1:0]   unit_component;
    logic [LEN_W-1:0]    length;
    logic                zero_length;
    logic                final_res;

    unit_result_t        pending_units[$];
    logic [COMP_W-1:0]   held_components [AXES];
    logic [SUM_W-1:0]    square_sum = '0;
    int                  taken_count = 0;

    int error_count = 0;
    int items_sent = 0;
    int results_checked = 0;
    int vectors_done = 0;
    int zero_vectors = 0;

    int gap_max = 0;
    int burst_left = 0;
    int stall_mode = 0;
    int stall_run = 0;
    logic stall_level = 1'b0;

    unit_vector_normalizer_top #(.AXES(AXES)) uut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .component      (component),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .axis_index     (axis_index),
        .unit_component (unit_component),
        .length         (length),
        .zero_length    (zero_length),
        .final_res      (final_res)
    );

    always #2 clk = ~clk;

    function automatic logic [32:0] magnitude(input logic [31:0] raw);
        if (raw[31])
            return 33'h1_0000_0000 - {1'b0, raw};
        return {1'b0, raw};
    endfunction

    function automatic logic [LEN_W-1:0] root_of_sum(input logic [SUM_W-1:0] s);
        logic [LEN_W-1:0] r;
        logic [LEN_W-1:0] c;
        logic [SUM_W-1:0] sq;
        int i;
        r = '0;
        for (i = LEN_W - 1; i >= 0; i--)
        begin
            c = r | (33'd1 << i);
            sq = SUM_W'(c) * SUM_W'(c);
            if (sq <= s)
                r = c;
        end
        return r;
    endfunction

    task automatic absorb_component(input logic [31:0] raw);
        logic [32:0] mag;
        logic [LEN_W-1:0] root;
        logic [63:0] quo;
        logic zero;
        unit_result_t r;
        int k;
        mag = magnitude(raw);
        held_components[taken_count] = raw;
        square_sum = square_sum + SUM_W'(mag) * SUM_W'(mag);
        if (taken_count + 1 < AXES)
        begin
            taken_count++;
        end
        else
        begin
            zero = (square_sum == '0);
            root = zero ? '0 : root_of_sum(square_sum);
            for (k = 0; k < AXES; k++)
            begin
                quo = '0;
                if (!zero && root != '0)
                begin
                    quo = (64'(magnitude(held_components[k])) << 30) / 64'(root);
                    if (quo > ONE_Q30)
                        quo = ONE_Q30;
                end
                r.axis = AXIS_W'(k);
                r.unit = held_components[k][31] ? (32'd0 - quo[31:0]) : quo[31:0];
                r.len  = root;
                r.zero = zero;
                r.last = (k == AXES - 1);
                pending_units.push_back(r);
            end
            if (zero)
                zero_vectors++;
            vectors_done++;
            square_sum = '0;
            taken_count = 0;
        end
    endtask

    task automatic report_field(input string name, input logic [32:0] want,
                                input logic [32:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
            error_count++;
        end
    endtask

    task automatic check_unit_result();
        unit_result_t want;
        if (pending_units.size() == 0)
        begin
            $display("%0t: unexpected result, axis %0d unit %h length %h", $time,
                     axis_index, unit_component, length);
            error_count++;
        end
        else
        begin
            want = pending_units.pop_front();
            report_field("axis_index", 33'(want.axis), 33'(axis_index));
            report_field("unit_component", 33'(want.unit), 33'(unit_component));
            report_field("length", want.len, length);
            report_field("zero_length", 33'(want.zero), 33'(zero_length));
            report_field("final_res", 33'(want.last), 33'(final_res));
            results_checked++;
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
                check_unit_result();
            if (in_valid && !in_stall)
                absorb_component(component);
        end
    end

    always @(negedge clk)
    begin
        if (stall_mode == 0)
        begin
            stall_level = 1'b0;
        end
        else if (stall_run == 0)
        begin
            stall_level = ($urandom_range(0, 99) < (stall_mode == 1 ? 30 : 65));
            stall_run = stall_level ? $urandom_range(1, stall_mode == 1 ? 6 : 24)
                                    : $urandom_range(1, 10);
        end
        else
        begin
            stall_run--;
        end
        out_stall <= stall_level;
    end

    task automatic idle_input(input int cycles);
        @(negedge clk);
        in_valid <= 1'b0;
        component <= $urandom;
        repeat (cycles - 1) @(negedge clk);
    endtask

    task automatic send_component(input logic [31:0] value);
        if (gap_max > 0 && burst_left == 0)
        begin
            idle_input($urandom_range(1, gap_max));
            burst_left = $urandom_range(1, 10);
        end
        @(negedge clk);
        in_valid <= 1'b1;
        component <= value;
        do @(posedge clk); while (in_stall);
        if (burst_left > 0)
            burst_left--;
        items_sent++;
    endtask

    function automatic logic [31:0] random_component();
        logic [31:0] v;
        case ($urandom_range(0, 9))
            0: v = '0;
            1: v = MOST_NEG;
            2: v = MOST_POS;
            3: v = $urandom_range(1, 255);
            4: v = $urandom_range(0, 32'h00ff_ffff);
            5: v = 32'd1;
            default: v = $urandom;
        endcase
        if (v != MOST_NEG && v != MOST_POS && $urandom_range(0, 1))
            v = 32'd0 - v;
        return v;
    endfunction

    task automatic send_random_vector();
        int shape;
        int hot;
        int k;
        logic [31:0] hot_value;
        shape = $urandom_range(0, 11);
        hot = $urandom_range(0, AXES - 1);
        hot_value = random_component();
        for (k = 0; k < AXES; k++)
        begin
            if (shape == 0)
                send_component('0);
            else if (shape <= 2)
                send_component(k == hot ? hot_value : '0);
            else
                send_component(random_component());
        end
    endtask

    task automatic test_directed_vectors();
        logic [31:0] vecs [4][AXES];
        int v;
        int k;
        vecs = '{'{32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0},
                 '{32'd0, 32'd0, 32'd0, 32'd0, 32'd0, MOST_NEG},
                 '{MOST_POS, MOST_NEG, MOST_POS, MOST_NEG, MOST_POS, MOST_NEG},
                 '{32'd1, 32'hffff_ffff, 32'd0, 32'd3, 32'hffff_fffe, 32'h0000_7fff}};
        gap_max = 0;
        stall_mode = 0;
        for (v = 0; v < 4; v++)
            for (k = 0; k < AXES; k++)
                send_component(vecs[v][k]);
        idle_input(1);
    endtask

    task automatic test_random_vectors();
        gap_max = 12;
        stall_mode = 1;
        repeat (32) send_random_vector();
        idle_input(1);
    endtask

    task automatic test_streaming_vectors();
        gap_max = 0;
        stall_mode = 0;
        repeat (10) send_random_vector();
        idle_input(1);
    endtask

    task automatic test_backpressure_vectors();
        gap_max = 4;
        stall_mode = 2;
        repeat (9) send_random_vector();
        idle_input(1);
    endtask

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        component = '0;
        out_stall = 1'b0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_directed_vectors();
        test_random_vectors();
        test_streaming_vectors();
        test_backpressure_vectors();

        stall_mode = 1;
        while (pending_units.size() != 0)
            @(posedge clk);
        repeat (300) @(posedge clk);

        $display("Sent %0d component transactions forming %0d vectors (%0d all zero).",
                 items_sent, vectors_done, zero_vectors);
        $display("Checked %0d unit components under input gaps, output stalls and streaming.",
                 results_checked);
        if (error_count == 0 && pending_units.size() == 0)
            $display("unit_vector_normalizer_top verification clean");
        else
            $display("unit_vector_normalizer_top verification failed");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("Timeout with %0d results still outstanding.", pending_units.size());
        $display("unit_vector_normalizer_top verification failed");
        $finish;
    end

endmodule
